@@ rtl/srh_pkg.sv @@
// shared types, constants and helpers for the ray segment hit and reflect block
package srh_pkg;

   localparam int DivBits   = 17;
   localparam int FrontDepth = 5;
   localparam int PipeDepth = FrontDepth + DivBits;
   localparam int NumWidth  = 52;
   localparam int DenWidth  = 34;

   typedef enum logic [2:0] {
      CSR_MIRROR_A_X = 3'd0,
      CSR_MIRROR_A_Y = 3'd1,
      CSR_MIRROR_B_X = 3'd2,
      CSR_MIRROR_B_Y = 3'd3,
      CSR_NORMAL_X   = 3'd4,
      CSR_NORMAL_Y   = 3'd5
   } csr_index_type;

   localparam logic signed [15:0] MirrorAXReset = 16'sd9600;
   localparam logic signed [15:0] MirrorAYReset = 16'sd2400;
   localparam logic signed [15:0] MirrorBXReset = 16'sd11200;
   localparam logic signed [15:0] MirrorBYReset = 16'sd4800;
   localparam logic signed [15:0] NormalXReset  = 16'sd13632;
   localparam logic signed [15:0] NormalYReset  = -16'sd9088;

   typedef struct packed {
      logic signed [15:0] ray_start_x;
      logic signed [15:0] ray_start_y;
      logic signed [15:0] ray_dir_x;
      logic signed [15:0] ray_dir_y;
   } req_type;

   typedef struct packed {
      logic               intersects;
      logic [15:0]        ray_dist;
      logic [16:0]        seg_frac;
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic signed [15:0] bounce_x;
      logic signed [15:0] bounce_y;
   } rsp_type;

   // flags and pass-through values that ride alongside the dividers
   typedef struct packed {
      logic               hit;
      logic               t_sat;
      logic               px_sat;
      logic               py_sat;
      logic               dx_neg;
      logic               dy_neg;
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic signed [15:0] rx;
      logic signed [15:0] ry;
   } side_type;

   function automatic logic signed [15:0] sat_s16(input logic signed [23:0] v);
      logic signed [15:0] r;
      if (v > 24'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -24'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/srh_div.sv @@
// pipelined restoring divider, one quotient bit per stage
module srh_div (
   input  logic                          clock,
   input  logic                          en,
   input  logic [srh_pkg::NumWidth-1:0]  num_in,
   input  logic [srh_pkg::DenWidth-1:0]  den_in,
   output logic [srh_pkg::DivBits-1:0]   quo,
   output logic                          rem_nz
);
   import srh_pkg::*;

   logic [NumWidth-1:0] rem_ff [DivBits];
   logic [DenWidth-1:0] den_ff [DivBits];
   logic [DivBits-1:0]  quo_ff [DivBits];

   for (genvar k = 0; k < DivBits; k++) begin : g_stage
      logic [NumWidth-1:0] src_rem;
      logic [DenWidth-1:0] src_den;
      logic [DivBits-1:0]  src_quo;
      logic [NumWidth-1:0] shifted;
      logic                ge;
      logic [NumWidth-1:0] rem_in;
      logic [DivBits-1:0]  quo_in;

      if (k == 0) begin : g_first
         assign src_rem = num_in;
         assign src_den = den_in;
         assign src_quo = '0;
      end else begin : g_next
         assign src_rem = rem_ff[k-1];
         assign src_den = den_ff[k-1];
         assign src_quo = quo_ff[k-1];
      end

      always_comb begin
         shifted = NumWidth'(src_den) << (DivBits - 1 - k);
         ge      = src_rem >= shifted;
         rem_in  = ge ? src_rem - shifted : src_rem;
         quo_in  = src_quo;
         quo_in[DivBits-1-k] = ge;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= src_den;
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign quo    = quo_ff[DivBits-1];
   assign rem_nz = rem_ff[DivBits-1] != '0;

endmodule

@@ rtl/ray_segment_hit_reflect.sv @@
// top level: ray against mirror segment intersection with reflected direction
// throughput: one request per cycle while no result is stalled, kept by the 17-stage bit-per-stage dividers
// a stalled result holds the whole pipeline; no request is accepted while it waits
// reset: synchronous, clears valid bits and restores the mirror and normal registers
// configuration writes are always ready and take effect at once
module ray_segment_hit_reflect (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  srh_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output srh_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_data
);
   import srh_pkg::*;

   logic signed [15:0] mirror_a_x_ff, mirror_a_y_ff, mirror_b_x_ff, mirror_b_y_ff;
   logic signed [15:0] normal_x_ff, normal_y_ff;

   logic en;
   logic [PipeDepth-1:0] vld_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   // stage 1
   logic signed [15:0] sx1_ff, sy1_ff, dx1_ff, dy1_ff;
   logic signed [16:0] vx1_ff, vy1_ff, wx1_ff, wy1_ff;
   // stage 2
   logic signed [15:0] sx2_ff, sy2_ff, dx2_ff, dy2_ff;
   logic signed [32:0] p_dxvy_ff, p_dyvx_ff, p_wxdy_ff, p_wydx_ff;
   logic signed [33:0] p_wxvy_ff, p_wyvx_ff;
   logic signed [31:0] p_dxnx_ff, p_dyny_ff;
   // stage 3
   logic signed [15:0] sx3_ff, sy3_ff, dx3_ff, dy3_ff;
   logic signed [33:0] denom3_ff, unum3_ff;
   logic signed [34:0] tnum3_ff;
   logic signed [32:0] dn3_ff;
   // stage 4
   logic signed [15:0] sx4_ff, sy4_ff, dx4_ff, dy4_ff;
   logic [DenWidth-1:0] den4_ff, den4_in;
   logic signed [34:0] tn4_ff, tn4_in, un4_ff, un4_in;
   logic hit4_ff, hit4_in;
   logic signed [49:0] rnx4_ff, rny4_ff;
   // stage 5
   logic [15:0] adx, ady;
   logic [49:0] mx, my;
   logic signed [49:0] sum_x, sum_y;
   logic signed [22:0] sh_x, sh_y;
   side_type side5_in, side5_ff;
   logic [NumWidth-1:0] num_t_ff, num_u_ff, num_px_ff, num_py_ff;
   logic [DenWidth-1:0] den5_ff;
   side_type side_ff [DivBits];

   logic [DivBits-1:0] q_t, q_u, q_px, q_py;
   logic nz_t, nz_u, nz_px, nz_py;

   logic [17:0] mag_x, mag_y;
   logic signed [18:0] val_x, val_y;
   logic signed [19:0] pos_x, pos_y;
   side_type side_out;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mirror_a_x_ff <= MirrorAXReset;
         mirror_a_y_ff <= MirrorAYReset;
         mirror_b_x_ff <= MirrorBXReset;
         mirror_b_y_ff <= MirrorBYReset;
         normal_x_ff   <= NormalXReset;
         normal_y_ff   <= NormalYReset;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIRROR_A_X: mirror_a_x_ff <= csr_data;
            CSR_MIRROR_A_Y: mirror_a_y_ff <= csr_data;
            CSR_MIRROR_B_X: mirror_b_x_ff <= csr_data;
            CSR_MIRROR_B_Y: mirror_b_y_ff <= csr_data;
            CSR_NORMAL_X:   normal_x_ff   <= csr_data;
            CSR_NORMAL_Y:   normal_y_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[PipeDepth-2:0], req_valid};
         rsp_valid_ff <= vld_ff[PipeDepth-1];
      end
   end

   // differences, products, sums
   always_ff @(posedge clock) begin
      if (en) begin
         sx1_ff <= req_data.ray_start_x;
         sy1_ff <= req_data.ray_start_y;
         dx1_ff <= req_data.ray_dir_x;
         dy1_ff <= req_data.ray_dir_y;
         vx1_ff <= {mirror_b_x_ff[15], mirror_b_x_ff} - {mirror_a_x_ff[15], mirror_a_x_ff};
         vy1_ff <= {mirror_b_y_ff[15], mirror_b_y_ff} - {mirror_a_y_ff[15], mirror_a_y_ff};
         wx1_ff <= {mirror_a_x_ff[15], mirror_a_x_ff}
                   - {req_data.ray_start_x[15], req_data.ray_start_x};
         wy1_ff <= {mirror_a_y_ff[15], mirror_a_y_ff}
                   - {req_data.ray_start_y[15], req_data.ray_start_y};

         sx2_ff    <= sx1_ff;
         sy2_ff    <= sy1_ff;
         dx2_ff    <= dx1_ff;
         dy2_ff    <= dy1_ff;
         p_dxvy_ff <= dx1_ff * vy1_ff;
         p_dyvx_ff <= dy1_ff * vx1_ff;
         p_wxvy_ff <= wx1_ff * vy1_ff;
         p_wyvx_ff <= wy1_ff * vx1_ff;
         p_wxdy_ff <= wx1_ff * dy1_ff;
         p_wydx_ff <= wy1_ff * dx1_ff;
         p_dxnx_ff <= dx1_ff * normal_x_ff;
         p_dyny_ff <= dy1_ff * normal_y_ff;

         sx3_ff    <= sx2_ff;
         sy3_ff    <= sy2_ff;
         dx3_ff    <= dx2_ff;
         dy3_ff    <= dy2_ff;
         denom3_ff <= p_dxvy_ff - p_dyvx_ff;
         tnum3_ff  <= p_wxvy_ff - p_wyvx_ff;
         unum3_ff  <= p_wxdy_ff - p_wydx_ff;
         dn3_ff    <= p_dxnx_ff + p_dyny_ff;
      end
   end

   // sign normalization and hit test
   always_comb begin
      if (denom3_ff[33]) begin
         den4_in = DenWidth'(-denom3_ff);
         tn4_in  = -tnum3_ff;
         un4_in  = -35'(unum3_ff);
      end else begin
         den4_in = DenWidth'(denom3_ff);
         tn4_in  = tnum3_ff;
         un4_in  = 35'(unum3_ff);
      end
      hit4_in = (denom3_ff != '0) && (tn4_in > 35'sd0) && !un4_in[34]
                && ($unsigned(un4_in) <= 35'(den4_in));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sx4_ff  <= sx3_ff;
         sy4_ff  <= sy3_ff;
         dx4_ff  <= dx3_ff;
         dy4_ff  <= dy3_ff;
         den4_ff <= den4_in;
         tn4_ff  <= tn4_in;
         un4_ff  <= un4_in;
         hit4_ff <= hit4_in;
         rnx4_ff <= dn3_ff * normal_x_ff;
         rny4_ff <= dn3_ff * normal_y_ff;
      end
   end

   // numerators, saturation flags, reflection
   always_comb begin
      adx   = dx4_ff[15] ? 16'(-dx4_ff) : 16'(dx4_ff);
      ady   = dy4_ff[15] ? 16'(-dy4_ff) : 16'(dy4_ff);
      mx    = 50'(adx) * 50'(tn4_ff[33:0]);
      my    = 50'(ady) * 50'(tn4_ff[33:0]);
      sum_x = rnx4_ff + (50'sd1 <<< 26);
      sum_y = rny4_ff + (50'sd1 <<< 26);
      sh_x  = sum_x[49:27];
      sh_y  = sum_y[49:27];
      side5_in.hit    = hit4_ff;
      side5_in.t_sat  = 38'(tn4_ff[33:0]) >= {1'b0, den4_ff, 3'b000};
      side5_in.px_sat = {2'b00, mx} >= {1'b0, den4_ff, 17'b0};
      side5_in.py_sat = {2'b00, my} >= {1'b0, den4_ff, 17'b0};
      side5_in.dx_neg = dx4_ff[15];
      side5_in.dy_neg = dy4_ff[15];
      side5_in.sx     = sx4_ff;
      side5_in.sy     = sy4_ff;
      side5_in.rx     = sat_s16(24'(dx4_ff) - 24'(sh_x));
      side5_in.ry     = sat_s16(24'(dy4_ff) - 24'(sh_y));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side5_ff  <= side5_in;
         den5_ff   <= den4_ff;
         num_t_ff  <= {4'b0, tn4_ff[33:0], 14'b0};
         num_u_ff  <= {2'b0, un4_ff[33:0], 16'b0};
         num_px_ff <= {2'b0, mx};
         num_py_ff <= {2'b0, my};
         side_ff[0] <= side5_ff;
         for (int k = 1; k < DivBits; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   srh_div u_div_t (
      .clock(clock), .en(en), .num_in(num_t_ff), .den_in(den5_ff), .quo(q_t), .rem_nz(nz_t)
   );
   srh_div u_div_u (
      .clock(clock), .en(en), .num_in(num_u_ff), .den_in(den5_ff), .quo(q_u), .rem_nz(nz_u)
   );
   srh_div u_div_px (
      .clock(clock), .en(en), .num_in(num_px_ff), .den_in(den5_ff), .quo(q_px), .rem_nz(nz_px)
   );
   srh_div u_div_py (
      .clock(clock), .en(en), .num_in(num_py_ff), .den_in(den5_ff), .quo(q_py), .rem_nz(nz_py)
   );

   // result assembly
   always_comb begin
      side_out = side_ff[DivBits-1];
      mag_x = 18'(q_px) + 18'(side_out.dx_neg && nz_px);
      mag_y = 18'(q_py) + 18'(side_out.dy_neg && nz_py);
      val_x = side_out.dx_neg ? -19'(mag_x) : 19'(mag_x);
      val_y = side_out.dy_neg ? -19'(mag_y) : 19'(mag_y);
      pos_x = 20'(side_out.sx) + 20'(val_x);
      pos_y = 20'(side_out.sy) + 20'(val_y);
      rsp_in = '0;
      if (side_out.hit) begin
         rsp_in.intersects = 1'b1;
         rsp_in.ray_dist   = (side_out.t_sat || q_t[16]) ? 16'hffff : q_t[15:0];
         rsp_in.seg_frac   = q_u;
         if (side_out.px_sat) begin
            rsp_in.point_x = side_out.dx_neg ? 16'sh8000 : 16'sh7fff;
         end else begin
            rsp_in.point_x = sat_s16(24'(pos_x));
         end
         if (side_out.py_sat) begin
            rsp_in.point_y = side_out.dy_neg ? 16'sh8000 : 16'sh7fff;
         end else begin
            rsp_in.point_y = sat_s16(24'(pos_y));
         end
         rsp_in.bounce_x = side_out.rx;
         rsp_in.bounce_y = side_out.ry;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.intersects |-> rsp_data.seg_frac <= 17'h10000)
      else $error("segment fraction above one");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.intersects |-> rsp_data.ray_dist == '0
         && rsp_data.seg_frac == '0 && rsp_data.point_x == '0 && rsp_data.point_y == '0
         && rsp_data.bounce_x == '0 && rsp_data.bounce_y == '0)
      else $error("miss result not cleared");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved during stall");
`endif

endmodule
